// File: sv/wsp_pkg.sv
// Package for wheel_speed_from_pulses: word widths shared by the top level
// and the serial divider. No dependencies.
package wsp_pkg;
  localparam int TIME_W  = 32;
  localparam int CFG_W   = 16;
  localparam int PROD_W  = TIME_W + CFG_W;
  localparam int NUM_W   = 61;
  localparam int DEN_W   = 51;
  localparam int QUOT_W  = 16;
  localparam int CIDX_W  = 2;

  localparam logic [CIDX_W-1:0] CFG_PPR     = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_CIRC    = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_TIMEOUT = 2'd2;

  localparam logic [CFG_W-1:0] PPR_RESET     = 16'd20;
  localparam logic [CFG_W-1:0] CIRC_RESET    = 16'd2000;
  localparam logic [CFG_W-1:0] TIMEOUT_RESET = 16'd2000;
endpackage

// File: sv/wsp_serial_div.sv
// Restoring divider for wheel_speed_from_pulses, one quotient bit per cycle.
// Quotient saturates at the 16-bit maximum. Depends on wsp_pkg.
module wsp_serial_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [wsp_pkg::NUM_W-1:0]   num,
  input  logic [wsp_pkg::DEN_W-1:0]   den,
  output logic                        done,
  output logic [wsp_pkg::QUOT_W-1:0]  quot
);
  import wsp_pkg::*;

  localparam int DSH_W = DEN_W + QUOT_W;

  logic               busy;
  logic [4:0]         cnt;
  logic [NUM_W-1:0]   rem;
  logic [DSH_W-1:0]   dsh;
  logic [QUOT_W:0]    q;
  logic [DSH_W:0]     diff;

  assign diff = {{(DSH_W + 1 - NUM_W){1'b0}}, rem} - {1'b0, dsh};
  assign quot = q[QUOT_W] ? {QUOT_W{1'b1}} : q[QUOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'(QUOT_W)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num;
      dsh <= {den, {QUOT_W{1'b0}}};
      q   <= '0;
    end else if (busy) begin
      if (!diff[DSH_W]) begin
        rem <= diff[NUM_W-1:0];
        q   <= {q[QUOT_W-1:0], 1'b1};
      end else begin
        q   <= {q[QUOT_W-1:0], 1'b0};
      end
      dsh <= {1'b0, dsh[DSH_W-1:1]};
    end
  end
endmodule

// File: sv/wheel_speed_from_pulses.sv
// Wheel speed from pulse readings: top level with config registers, state,
// shift-add multipliers and output register. Depends on wsp_pkg, wsp_serial_div.
//
// One reading in gives one word out: speed in km/h times 256 plus the timeout
// and config fault flags. A reading with no time passed, or with a fault, goes
// straight from taking the reading to the output register. Otherwise it is taken,
// passes through the shift-add multipliers (one bit of circumference and pulses
// per rev per cycle), forms numerator and denominator, goes through the restoring
// divider (17 quotient bits, one per cycle, then the quotient is passed back) and
// is handed to the output register.
// A new reading is taken as soon as the previous one has reached the output
// register, even while that word still waits. Config registers write at once.
module wheel_speed_from_pulses (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [wsp_pkg::TIME_W-1:0]    now_ms,
  input  logic [wsp_pkg::TIME_W-1:0]    pulse_total,
  input  logic [wsp_pkg::TIME_W-1:0]    latest_pulse_ms,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [wsp_pkg::QUOT_W-1:0]    speed_kmh_q8,
  output logic                          timeout_fault,
  output logic                          config_fault,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [wsp_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [wsp_pkg::CFG_W-1:0]     cfg_data
);
  import wsp_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_LOAD = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state;

  logic [CFG_W-1:0]  ppr;
  logic [CFG_W-1:0]  circ;
  logic [CFG_W-1:0]  timeout;

  logic [TIME_W-1:0] prev_total;
  logic [TIME_W-1:0] prev_read_time;
  logic              timeout_flag;
  logic              config_flag;

  logic [PROD_W-1:0] mcand_n;
  logic [PROD_W-1:0] mcand_d;
  logic [CFG_W-1:0]  mplier_n;
  logic [CFG_W-1:0]  mplier_d;
  logic [PROD_W-1:0] acc_n;
  logic [PROD_W-1:0] acc_d;
  logic [3:0]        mul_cnt;
  logic [QUOT_W-1:0] res_speed;

  logic              in_accept;
  logic              out_free;
  logic [TIME_W-1:0] elapsed;
  logic [TIME_W-1:0] delta;
  logic [TIME_W-1:0] age;
  logic              timeout_new;
  logic              config_new;
  logic [NUM_W-1:0]  num;
  logic [DEN_W-1:0]  den;
  logic              div_start;
  logic              div_done;
  logic [QUOT_W-1:0] div_quot;

  assign cfg_ready   = 1'b1;
  assign in_stall    = (state != S_IDLE);
  assign in_accept   = in_valid && !in_stall;
  assign out_free    = !out_valid || !out_stall;
  assign elapsed     = now_ms - prev_read_time;
  assign delta       = pulse_total - prev_total;
  assign age         = now_ms - latest_pulse_ms;
  assign timeout_new = (age >= {{(TIME_W - CFG_W){1'b0}}, timeout});
  assign config_new  = (ppr == '0) || (circ == '0);

  // 4608 = 2^12 + 2^9, 5 = 2^2 + 1
  assign num = {1'b0, acc_n, 12'b0} + {4'b0, acc_n, 9'b0};
  assign den = {1'b0, acc_d, 2'b0} + {3'b0, acc_d};
  assign div_start = (state == S_LOAD);

  wsp_serial_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ppr     <= PPR_RESET;
      circ    <= CIRC_RESET;
      timeout <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PPR:     ppr     <= cfg_data;
        CFG_CIRC:    circ    <= cfg_data;
        CFG_TIMEOUT: timeout <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      prev_total     <= '0;
      prev_read_time <= '0;
      timeout_flag   <= 1'b0;
      config_flag    <= 1'b0;
      mul_cnt        <= '0;
    end else begin
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            mul_cnt <= '0;
            if (elapsed != '0) begin
              prev_total     <= pulse_total;
              prev_read_time <= now_ms;
              timeout_flag   <= timeout_new;
              config_flag    <= config_new;
            end
            if (elapsed == '0 || timeout_new || config_new) begin
              state <= S_DONE;
            end else begin
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          mul_cnt <= mul_cnt + 4'd1;
          if (mul_cnt == 4'hF) begin
            state <= S_LOAD;
          end
        end
        S_LOAD: state <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_accept) begin
      mcand_n   <= {{(PROD_W - TIME_W){1'b0}}, delta};
      mcand_d   <= {{(PROD_W - TIME_W){1'b0}}, elapsed};
      mplier_n  <= circ;
      mplier_d  <= ppr;
      acc_n     <= '0;
      acc_d     <= '0;
      res_speed <= '0;
    end else if (state == S_MUL) begin
      if (mplier_n[0]) acc_n <= acc_n + mcand_n;
      if (mplier_d[0]) acc_d <= acc_d + mcand_d;
      mcand_n  <= {mcand_n[PROD_W-2:0], 1'b0};
      mcand_d  <= {mcand_d[PROD_W-2:0], 1'b0};
      mplier_n <= {1'b0, mplier_n[CFG_W-1:1]};
      mplier_d <= {1'b0, mplier_d[CFG_W-1:1]};
    end else if (state == S_DIV && div_done) begin
      res_speed <= div_quot;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      speed_kmh_q8  <= res_speed;
      timeout_fault <= timeout_flag;
      config_fault  <= config_flag;
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (state == S_MUL || state == S_DONE))
    else $error("accepted reading did not start work");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside divide state");

  a_load_to_div: assert property (@(posedge clk) disable iff (rst)
    state == S_LOAD |=> state == S_DIV)
    else $error("divider start not followed by divide state");

  a_fault_zero_speed: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (timeout_fault || config_fault)) |-> speed_kmh_q8 == '0)
    else $error("nonzero speed with fault flag set");
endmodule
